[rtl/core/histogram_cdf_emd_two_channel_assert.svh]
// assertion macros for the checker file of the histogram distance block
// depends on nothing; included by bare file name
`ifndef HISTOGRAM_CDF_EMD_TWO_CHANNEL_ASSERT_SVH
`define HISTOGRAM_CDF_EMD_TWO_CHANNEL_ASSERT_SVH

// same-cycle implication, held off during reset
`define HCEMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define HCEMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hcemd_pkg.sv]
// shared types and fixed field layout of the histogram distance block
// no dependencies
package hcemd_pkg;

    // input color channel format, unsigned q5.8
    localparam int CHAN_W      = 13;
    localparam int CHAN_FRAC   = 8;

    // input beat layout
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int TUSER_REGION = 0;
    localparam int TUSER_PIXEL  = 1;
    localparam int CHAN_A_LSB  = 0;
    localparam int CHAN_B_LSB  = CHAN_W;

    // output beat layout
    localparam int OUT_TUSER_W = 1;

    // sequencer states, one-hot
    typedef enum logic [17:0] {
        S_CLEAR = 18'h00001,
        S_IDLE  = 18'h00002,
        S_INC   = 18'h00004,
        S_RD    = 18'h00008,
        S_CUM   = 18'h00010,
        S_PA    = 18'h00020,
        S_QA    = 18'h00040,
        S_PB    = 18'h00080,
        S_QB    = 18'h00100,
        S_DB    = 18'h00200,
        S_AB    = 18'h00400,
        S_DEN0  = 18'h00800,
        S_DEN1  = 18'h01000,
        S_CMP   = 18'h02000,
        S_INT   = 18'h04000,
        S_DIV   = 18'h08000,
        S_RND   = 18'h10000,
        S_EMIT  = 18'h20000
    } state_t;

endpackage

[rtl/core/hcemd_ram.sv]
// generic single-write, single-read ram with registered read (read-first)
// no dependencies
module hcemd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/histogram_cdf_emd_two_channel.sv]
// top level of the two-channel histogram earth mover's distance block
// depends on hcemd_pkg and hcemd_ram
//
// Pixels of two regions stream in on the slave side, one beat per pixel, each
// carrying a channel A and a channel B value in unsigned q5.8. Each value is
// rounded half up to a bin 1..BINS (clamped) and counted in that region's
// histogram for that channel; a pixel beat does a registered ram read, then a
// saturating write back, and a bare marker beat without tlast counts nothing.
// A beat with tlast (counted first if it carries a pixel) starts the distance
// pass: one shared multiplier walks the bins, one bin at a time, forming the
// cross-scaled cumulative differences |C1*n2 - C2*n1| for both channels, then
// a bit-serial divider gives (sum_a + sum_b) / (n1*n2*BINS) rounded half up
// to q1.OUT_FRAC_BITS, saturated. s_tready is low for the whole pass, the bin
// walk through the shared multiplier and the one-bit-per-cycle divider alike.
// The walk zeroes each bin as it reads it, so the histograms are clean for
// the next pair. One result beat per tlast beat leaves through an output
// register; m_tuser flags an empty region, with distance forced to zero.
// After reset the block clears every bin of the histogram rams before
// raising s_tready.
module histogram_cdf_emd_two_channel
    import hcemd_pkg::*;
#(
    parameter int BINS          = 20,
    parameter int COUNT_BITS    = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave side
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [IN_TDATA_W-1:0]                 s_tdata,  // chan_a_value, chan_b_value, zero pad
    input  logic [IN_TUSER_W-1:0]                 s_tuser,  // region, pixel_valid
    input  logic                                  s_tlast,
    // master side
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((OUT_FRAC_BITS+8)/8)*8-1:0]    m_tdata,  // distance, zero pad
    output logic [OUT_TUSER_W-1:0]                m_tuser   // empty_region
);

    // widths that follow from the parameters
    localparam int BIN_W    = $clog2(BINS);
    localparam int BNUM_W   = ($clog2(BINS + 1) > CHAN_W + 1 - CHAN_FRAC) ?
                              $clog2(BINS + 1) : CHAN_W + 1 - CHAN_FRAC;
    localparam int CUM_W    = COUNT_BITS + $clog2(BINS);
    localparam int PROD_W   = CUM_W + COUNT_BITS;
    localparam int ACC_W    = PROD_W + $clog2(2 * BINS);
    localparam int DEN_W    = 2 * COUNT_BITS + $clog2(BINS);
    localparam int DIST_W   = OUT_FRAC_BITS + 1;
    localparam int Q_W      = OUT_FRAC_BITS + 2;
    localparam int DCNT_W   = $clog2(OUT_FRAC_BITS);
    localparam int OTDATA_W = ((OUT_FRAC_BITS + 8) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [BIN_W-1:0]  BIN_LAST = BIN_W'(BINS - 1);

    // ram lanes
    localparam int RAM_FA = 0;
    localparam int RAM_FB = 1;
    localparam int RAM_SA = 2;
    localparam int RAM_SB = 3;
    localparam int NRAM   = 4;

    // value to zero-based bin index, round half up and clamp to 1..BINS
    function automatic logic [BIN_W-1:0] to_bin(input logic [CHAN_W-1:0] v);
        logic [CHAN_W:0]   sum;
        logic [BNUM_W-1:0] b;
        sum = {1'b0, v} + (CHAN_W + 1)'(1 << (CHAN_FRAC - 1));
        b   = BNUM_W'(sum >> CHAN_FRAC);
        if (b == '0)
        begin
            b = BNUM_W'(1);
        end
        if (b > BNUM_W'(BINS))
        begin
            b = BNUM_W'(BINS);
        end
        return BIN_W'(b - BNUM_W'(1));
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

    // sequencer and control
    state_t                  state_reg, state_next;
    logic [BIN_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [BIN_W-1:0]        k_reg, k_next;
    logic [DCNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [COUNT_BITS-1:0]   count_first_reg, count_first_next;
    logic [COUNT_BITS-1:0]   count_second_reg, count_second_next;
    logic                    last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;

    // latched beat
    logic                    region_reg, region_next;
    logic [BIN_W-1:0]        bin_a_reg, bin_a_next;
    logic [BIN_W-1:0]        bin_b_reg, bin_b_next;

    // datapath
    logic [CUM_W-1:0]        cum_fa_reg, cum_fa_next;
    logic [CUM_W-1:0]        cum_sa_reg, cum_sa_next;
    logic [CUM_W-1:0]        cum_fb_reg, cum_fb_next;
    logic [CUM_W-1:0]        cum_sb_reg, cum_sb_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [PROD_W-1:0]       p_reg, p_next;
    logic [PROD_W-1:0]       diff_reg, diff_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        r_reg, r_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic                    sat_reg, sat_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic [DIST_W-1:0]       out_dist_reg, out_dist_next;
    logic                    out_empty_reg, out_empty_next;

    // shared multiplier
    logic [CUM_W-1:0]        mul_x;
    logic [COUNT_BITS-1:0]   mul_y;
    logic [PROD_W-1:0]       mul_out;

    // ram ports
    logic                    ram_wr_en   [NRAM];
    logic [BIN_W-1:0]        ram_wr_addr [NRAM];
    logic [COUNT_BITS-1:0]   ram_wr_data [NRAM];
    logic [BIN_W-1:0]        ram_rd_addr [NRAM];
    logic [COUNT_BITS-1:0]   ram_rd_data [NRAM];

    logic                    in_beat;
    logic [BIN_W-1:0]        in_bin_a;
    logic [BIN_W-1:0]        in_bin_b;
    logic                    empty;
    logic [DEN_W:0]          rem_shift;
    logic [Q_W-1:0]          q_round;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_bin_a = to_bin(s_tdata[CHAN_A_LSB +: CHAN_W]);
    assign in_bin_b = to_bin(s_tdata[CHAN_B_LSB +: CHAN_W]);
    assign empty    = (count_first_reg == '0) || (count_second_reg == '0);
    assign rem_shift = {r_reg, 1'b0};
    assign q_round  = q_reg + Q_W'(rem_shift >= {1'b0, den_reg});

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OTDATA_W'(out_dist_reg);
    assign m_tuser  = out_empty_reg;

    // histogram rams: first a, first b, second a, second b
    for (genvar g = 0; g < NRAM; g++)
    begin : g_ram
        hcemd_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (BINS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (ram_wr_en[g]),
            .wr_addr (ram_wr_addr[g]),
            .wr_data (ram_wr_data[g]),
            .rd_addr (ram_rd_addr[g]),
            .rd_data (ram_rd_data[g])
        );
    end

    // ram control
    always_comb
    begin
        for (int i = 0; i < NRAM; i++)
        begin
            ram_wr_en[i]   = 1'b0;
            ram_wr_addr[i] = k_reg;
            ram_wr_data[i] = '0;
            ram_rd_addr[i] = k_reg;
        end
        case (state_reg)
            S_CLEAR:
            begin
                for (int i = 0; i < NRAM; i++)
                begin
                    ram_wr_en[i]   = 1'b1;
                    ram_wr_addr[i] = clr_idx_reg;
                end
            end
            S_IDLE:
            begin
                // read ahead of the increment, both regions
                ram_rd_addr[RAM_FA] = in_bin_a;
                ram_rd_addr[RAM_SA] = in_bin_a;
                ram_rd_addr[RAM_FB] = in_bin_b;
                ram_rd_addr[RAM_SB] = in_bin_b;
            end
            S_INC:
            begin
                if (!region_reg)
                begin
                    ram_wr_en[RAM_FA]   = 1'b1;
                    ram_wr_en[RAM_FB]   = 1'b1;
                end
                else
                begin
                    ram_wr_en[RAM_SA]   = 1'b1;
                    ram_wr_en[RAM_SB]   = 1'b1;
                end
                ram_wr_addr[RAM_FA] = bin_a_reg;
                ram_wr_addr[RAM_SA] = bin_a_reg;
                ram_wr_addr[RAM_FB] = bin_b_reg;
                ram_wr_addr[RAM_SB] = bin_b_reg;
                for (int i = 0; i < NRAM; i++)
                begin
                    ram_wr_data[i] = sat_inc(ram_rd_data[i]);
                end
            end
            S_RD:
            begin
                // read-first ram: old count comes out, bin is zeroed behind it
                for (int i = 0; i < NRAM; i++)
                begin
                    ram_wr_en[i] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_x = cum_fa_reg;
        mul_y = count_second_reg;
        case (state_reg)
            S_QA:
            begin
                mul_x = cum_sa_reg;
                mul_y = count_first_reg;
            end
            S_PB:
            begin
                mul_x = cum_fb_reg;
                mul_y = count_second_reg;
            end
            S_QB:
            begin
                mul_x = cum_sb_reg;
                mul_y = count_first_reg;
            end
            S_DEN0:
            begin
                mul_x = CUM_W'(count_first_reg);
                mul_y = count_second_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_out = mul_x * mul_y;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        k_next            = k_reg;
        div_cnt_next      = div_cnt_reg;
        count_first_next  = count_first_reg;
        count_second_next = count_second_reg;
        last_next         = last_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        region_next       = region_reg;
        bin_a_next        = bin_a_reg;
        bin_b_next        = bin_b_reg;
        cum_fa_next       = cum_fa_reg;
        cum_sa_next       = cum_sa_reg;
        cum_fb_next       = cum_fb_reg;
        cum_sb_next       = cum_sb_reg;
        prod_next         = prod_reg;
        p_next            = p_reg;
        diff_next         = diff_reg;
        acc_next          = acc_reg;
        den_next          = den_reg;
        r_next            = r_reg;
        q_next            = q_reg;
        sat_next          = sat_reg;
        dist_next         = dist_reg;
        out_dist_next     = out_dist_reg;
        out_empty_next    = out_empty_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + BIN_W'(1);
                if (clr_idx_reg == BIN_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    region_next = s_tuser[TUSER_REGION];
                    bin_a_next  = in_bin_a;
                    bin_b_next  = in_bin_b;
                    last_next   = s_tlast;
                    if (s_tuser[TUSER_PIXEL])
                    begin
                        state_next = S_INC;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_INC:
            begin
                if (!region_reg)
                begin
                    count_first_next = sat_inc(count_first_reg);
                end
                else
                begin
                    count_second_next = sat_inc(count_second_reg);
                end
                state_next = last_reg ? S_RD : S_IDLE;
            end
            S_RD:
            begin
                if (k_reg == '0)
                begin
                    // fresh walk
                    cum_fa_next = '0;
                    cum_sa_next = '0;
                    cum_fb_next = '0;
                    cum_sb_next = '0;
                    acc_next    = '0;
                end
                state_next = S_CUM;
            end
            S_CUM:
            begin
                cum_fa_next = cum_fa_reg + CUM_W'(ram_rd_data[RAM_FA]);
                cum_sa_next = cum_sa_reg + CUM_W'(ram_rd_data[RAM_SA]);
                cum_fb_next = cum_fb_reg + CUM_W'(ram_rd_data[RAM_FB]);
                cum_sb_next = cum_sb_reg + CUM_W'(ram_rd_data[RAM_SB]);
                state_next  = S_PA;
            end
            S_PA:
            begin
                prod_next  = mul_out;
                state_next = S_QA;
            end
            S_QA:
            begin
                p_next     = prod_reg;
                prod_next  = mul_out;
                state_next = S_PB;
            end
            S_PB:
            begin
                diff_next  = (p_reg >= prod_reg) ? p_reg - prod_reg : prod_reg - p_reg;
                prod_next  = mul_out;
                state_next = S_QB;
            end
            S_QB:
            begin
                acc_next   = acc_reg + ACC_W'(diff_reg);
                p_next     = prod_reg;
                prod_next  = mul_out;
                state_next = S_DB;
            end
            S_DB:
            begin
                diff_next  = (p_reg >= prod_reg) ? p_reg - prod_reg : prod_reg - p_reg;
                state_next = S_AB;
            end
            S_AB:
            begin
                acc_next = acc_reg + ACC_W'(diff_reg);
                if (k_reg == BIN_LAST)
                begin
                    k_next     = '0;
                    state_next = S_DEN0;
                end
                else
                begin
                    k_next     = k_reg + BIN_W'(1);
                    state_next = S_RD;
                end
            end
            S_DEN0:
            begin
                prod_next  = mul_out;
                state_next = S_DEN1;
            end
            S_DEN1:
            begin
                den_next   = DEN_W'(DEN_W'(prod_reg) * DEN_W'(BINS));
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // quotient of two or more saturates
                sat_next   = acc_reg >= ACC_W'({den_reg, 1'b0});
                state_next = S_INT;
            end
            S_INT:
            begin
                if (sat_reg)
                begin
                    state_next = S_RND;
                end
                else
                begin
                    if (acc_reg >= ACC_W'(den_reg))
                    begin
                        r_next = DEN_W'(acc_reg - ACC_W'(den_reg));
                        q_next = Q_W'(1);
                    end
                    else
                    begin
                        r_next = DEN_W'(acc_reg);
                        q_next = '0;
                    end
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                // one fraction bit per cycle
                if (rem_shift >= {1'b0, den_reg})
                begin
                    r_next = DEN_W'(rem_shift - {1'b0, den_reg});
                    q_next = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = DEN_W'(rem_shift);
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(OUT_FRAC_BITS - 1))
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                if (sat_reg || (q_round > Q_W'(DIST_MAX)))
                begin
                    dist_next = DIST_MAX;
                end
                else
                begin
                    dist_next = DIST_W'(q_round);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next    = 1'b1;
                    out_dist_next     = empty ? '0 : dist_reg;
                    out_empty_next    = empty;
                    count_first_next  = '0;
                    count_second_next = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            k_reg            <= '0;
            div_cnt_reg      <= '0;
            count_first_reg  <= '0;
            count_second_reg <= '0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            k_reg            <= k_next;
            div_cnt_reg      <= div_cnt_next;
            count_first_reg  <= count_first_next;
            count_second_reg <= count_second_next;
            last_reg         <= last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        region_reg    <= region_next;
        bin_a_reg     <= bin_a_next;
        bin_b_reg     <= bin_b_next;
        cum_fa_reg    <= cum_fa_next;
        cum_sa_reg    <= cum_sa_next;
        cum_fb_reg    <= cum_fb_next;
        cum_sb_reg    <= cum_sb_next;
        prod_reg      <= prod_next;
        p_reg         <= p_next;
        diff_reg      <= diff_next;
        acc_reg       <= acc_next;
        den_reg       <= den_next;
        r_reg         <= r_next;
        q_reg         <= q_next;
        sat_reg       <= sat_next;
        dist_reg      <= dist_next;
        out_dist_reg  <= out_dist_next;
        out_empty_reg <= out_empty_next;
    end

endmodule

[rtl/core/hcemd_checker.sv]
// port-level checker for the histogram distance block, bound to the top level
// depends on histogram_cdf_emd_two_channel_assert.svh
`include "histogram_cdf_emd_two_channel_assert.svh"

module hcemd_checker #(
    parameter int DATA_W = 24
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [0:0]        m_tuser
);

    // a stalled result beat holds
    `HCEMD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // an empty region always reports zero distance
    `HCEMD_ASSERT_NOW(a_empty_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == '0, "empty region with nonzero distance")

    // the distance pass keeps input closed right after a closing beat
    `HCEMD_ASSERT_NEXT(a_busy_after_last, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input open right after closing beat")

    // no result can appear in the cycle after an input beat
    `HCEMD_ASSERT_NEXT(a_no_instant_result, clk, rst_n, s_tvalid && s_tready, !$rose(m_tvalid), "result raised right after an input beat")

endmodule

bind histogram_cdf_emd_two_channel hcemd_checker #(
    .DATA_W ($bits(m_tdata))
) u_hcemd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
